>>> design/asnz_pkg.sv
// Shared types and constants for the alarm slot block with snooze.
// Holds the command codes, the input and result word layouts, and the
// epoch-seconds to epoch-minute conversion. No dependencies.
package asnz_pkg;

  localparam int NUM_ALARMS_DEFAULT = 4;

  localparam int EPOCH_W   = 32;
  localparam int MINUTE_W  = 27;
  localparam int HOUR_W    = 5;
  localparam int MIN_W     = 6;
  localparam int SLOT_W    = 2;
  localparam int SNOOZE_W  = 8;

  localparam logic [HOUR_W-1:0]   MAX_HOUR   = 5'd23;
  localparam logic [MIN_W-1:0]    MAX_MINUTE = 6'd59;
  localparam logic [SNOOZE_W-1:0] DEFAULT_SNOOZE_RESET = 8'd5;
  localparam logic [MINUTE_W-1:0] MINUTE_NONE = '1;

  // ceil(2^34 / 15): x / 60 == (x >> 2) / 15 for every 32-bit x
  localparam logic [30:0] RECIP_15 = 31'h4444_4445;
  localparam int RECIP_SHIFT = 34;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_SET     = 2'd1,
    CMD_SNOOZE  = 2'd2,
    CMD_DISMISS = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [EPOCH_W-1:0]   epoch_seconds;
    logic [HOUR_W-1:0]    clock_hour;
    logic [MIN_W-1:0]     clock_minute;
    logic [SLOT_W-1:0]    slot;
    logic [7:0]           set_hour;
    logic [7:0]           set_minute;
    logic                 set_enable;
    logic [SNOOZE_W-1:0]  snooze_minutes;
  } in_t;

  typedef struct packed {
    logic                 ring_start;
    logic                 ring_stop;
    logic [SLOT_W-1:0]    ring_slot;
    logic                 ringing;
    logic                 snooze_pending;
    logic [SLOT_W-1:0]    snooze_for_slot;
    logic [HOUR_W-1:0]    entry_hour;
    logic [MIN_W-1:0]     entry_minute;
    logic                 entry_enabled;
  } out_t;

  // Epoch minute by reciprocal multiply; exact over the full 32-bit range.
  function automatic logic [MINUTE_W-1:0] epoch_minute(input logic [EPOCH_W-1:0] epoch);
    logic [29:0] quarter;
    logic [60:0] prod;
    quarter = epoch[EPOCH_W-1:2];
    prod    = 61'(quarter) * 61'(RECIP_15);
    return prod[RECIP_SHIFT+MINUTE_W-1:RECIP_SHIFT];
  endfunction

endpackage

>>> design/alarm_slots_with_snooze.sv
// Top level of the alarm slot block with snooze: slot table, ring and
// snooze state, input and result registers. Depends on asnz_pkg.
module alarm_slots_with_snooze #(
  parameter int NUM_ALARMS = asnz_pkg::NUM_ALARMS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  // Command words
  input  logic            in_valid,
  output logic            in_stall,
  input  asnz_pkg::in_t   in_data,
  // Result words
  output logic            out_valid,
  input  logic            out_stall,
  output asnz_pkg::out_t  out_data,
  // Default snooze length register
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [asnz_pkg::SNOOZE_W-1:0] cfg_data
);

  // How to use this block
  // - Command words enter on in_valid/in_stall/in_data: tick, set slot,
  //   snooze or dismiss. Every word yields exactly one result word on
  //   out_valid/out_stall/out_data, in order.
  // - A word passes from the input register to the result register, where
  //   out_valid rises. One word is accepted every cycle unless the receiver
  //   stalls: the epoch minute (a 30x31 reciprocal multiply), the slot
  //   compare and the state update run between the two registers, so
  //   back-to-back words see each other's state updates.
  // - When the receiver stalls, the result register holds its word and the
  //   input register still fills; in_stall rises only when both registers
  //   are full.
  // - cfg_valid/cfg_data write the default snooze length (used when a
  //   snooze word asks for zero minutes). cfg_ready is always high; write it
  //   only while no command word is in flight.
  // - Synchronous reset clears all slots, the fire history, ring and snooze
  //   state and both registers, and sets the default snooze length to 5.
  //   The block takes words in the cycle after reset drops.

  localparam int IDX_W = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
  localparam int MW    = asnz_pkg::MINUTE_W;
  localparam int HW    = asnz_pkg::HOUR_W;
  localparam int NW    = asnz_pkg::MIN_W;
  localparam int SW    = asnz_pkg::SLOT_W;
  localparam int EW    = asnz_pkg::EPOCH_W;

  // Input register
  logic             s1_valid;
  asnz_pkg::in_t    s1_item;

  logic out_ready, s1_ready, s1_fire;

  // Architectural state
  logic [asnz_pkg::SNOOZE_W-1:0] default_snooze_minutes;
  logic [HW-1:0]  alarm_hour        [NUM_ALARMS];
  logic [NW-1:0]  alarm_minute      [NUM_ALARMS];
  logic           alarm_enabled     [NUM_ALARMS];
  logic [MW-1:0]  last_fired_minute [NUM_ALARMS];
  logic [MW-1:0]  last_evaluated_minute;
  logic           ringing_flag;
  logic [SW-1:0]  ringing_slot;
  logic           snooze_flag;
  logic [SW-1:0]  snooze_slot;
  logic [EW-1:0]  snooze_deadline;

  logic [HW-1:0]  alarm_hour_next        [NUM_ALARMS];
  logic [NW-1:0]  alarm_minute_next      [NUM_ALARMS];
  logic           alarm_enabled_next     [NUM_ALARMS];
  logic [MW-1:0]  last_fired_minute_next [NUM_ALARMS];
  logic [MW-1:0]  last_evaluated_minute_next;
  logic           ringing_flag_next;
  logic [SW-1:0]  ringing_slot_next;
  logic           snooze_flag_next;
  logic [SW-1:0]  snooze_slot_next;
  logic [EW-1:0]  snooze_deadline_next;

  // Step logic
  logic [MW-1:0]         minute_now;
  logic [NUM_ALARMS-1:0] slot_match;
  logic [IDX_W-1:0]      pick;
  logic [IDX_W-1:0]      idx;
  logic                  slot_ok;
  logic                  snooze_due;
  logic [asnz_pkg::SNOOZE_W-1:0] snooze_len;
  logic [13:0]           snooze_secs;
  logic                  start, stop;
  asnz_pkg::out_t        result;

  // Handshake: each register takes a word when empty or when it drains.
  assign out_ready = !out_valid || !out_stall;
  assign s1_ready  = !s1_valid || out_ready;
  assign in_stall  = !s1_ready;
  assign s1_fire   = s1_valid && out_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (out_ready) begin
        out_valid <= s1_valid;
      end
    end
    if (s1_ready && in_valid) begin
      s1_item <= in_data;
    end
    if (s1_fire) begin
      out_data <= result;
    end
  end

  // Epoch minute of the held word.
  assign minute_now = asnz_pkg::epoch_minute(s1_item.epoch_seconds);

  // Slot addressed by the word; slots past the table are ignored.
  assign idx     = IDX_W'(s1_item.slot);
  assign slot_ok = 32'(s1_item.slot) < NUM_ALARMS;

  // Per-slot compare against the local clock, in parallel.
  always_comb begin
    for (int i = 0; i < NUM_ALARMS; i++) begin
      slot_match[i] = alarm_enabled[i]
                   && (alarm_hour[i] == s1_item.clock_hour)
                   && (alarm_minute[i] == s1_item.clock_minute)
                   && (last_fired_minute[i] != minute_now);
    end
  end

  // Lowest matching slot wins.
  always_comb begin
    pick = '0;
    for (int i = NUM_ALARMS - 1; i >= 0; i--) begin
      if (slot_match[i]) begin
        pick = IDX_W'(i);
      end
    end
  end

  assign snooze_due  = snooze_flag && (s1_item.epoch_seconds >= snooze_deadline);
  assign snooze_len  = (s1_item.snooze_minutes != '0) ? s1_item.snooze_minutes
                                                       : default_snooze_minutes;
  // minutes * 60 as (m << 6) - (m << 2)
  assign snooze_secs = {snooze_len, 6'b0} - {4'b0, snooze_len, 2'b0};

  always_comb begin
    for (int i = 0; i < NUM_ALARMS; i++) begin
      alarm_hour_next[i]        = alarm_hour[i];
      alarm_minute_next[i]      = alarm_minute[i];
      alarm_enabled_next[i]     = alarm_enabled[i];
      last_fired_minute_next[i] = last_fired_minute[i];
    end
    last_evaluated_minute_next = last_evaluated_minute;
    ringing_flag_next    = ringing_flag;
    ringing_slot_next    = ringing_slot;
    snooze_flag_next     = snooze_flag;
    snooze_slot_next     = snooze_slot;
    snooze_deadline_next = snooze_deadline;
    start = 1'b0;
    stop  = 1'b0;

    unique case (s1_item.cmd)
      asnz_pkg::CMD_TICK: begin
        // Ignore ticks while ringing; a due snooze beats the minute check.
        if (!ringing_flag) begin
          if (snooze_due) begin
            snooze_flag_next     = 1'b0;
            snooze_slot_next     = '0;
            snooze_deadline_next = '0;
            ringing_flag_next    = 1'b1;
            ringing_slot_next    = snooze_slot;
            last_fired_minute_next[IDX_W'(snooze_slot)] = minute_now;
            start = 1'b1;
          end else if (minute_now != last_evaluated_minute) begin
            last_evaluated_minute_next = minute_now;
            if (|slot_match) begin
              ringing_flag_next            = 1'b1;
              ringing_slot_next            = SW'(pick);
              last_fired_minute_next[pick] = minute_now;
              snooze_flag_next             = 1'b0;
              snooze_slot_next             = '0;
              snooze_deadline_next         = '0;
              start = 1'b1;
            end
          end
        end
      end
      asnz_pkg::CMD_SET: begin
        // Clamp to 23:59; editing the snoozed slot drops its snooze.
        if (slot_ok) begin
          alarm_hour_next[idx] = (s1_item.set_hour > 8'(asnz_pkg::MAX_HOUR))
                               ? asnz_pkg::MAX_HOUR : s1_item.set_hour[HW-1:0];
          alarm_minute_next[idx] = (s1_item.set_minute > 8'(asnz_pkg::MAX_MINUTE))
                                 ? asnz_pkg::MAX_MINUTE : s1_item.set_minute[NW-1:0];
          alarm_enabled_next[idx] = s1_item.set_enable;
          if (snooze_flag && (snooze_slot == s1_item.slot)) begin
            snooze_flag_next     = 1'b0;
            snooze_slot_next     = '0;
            snooze_deadline_next = '0;
          end
        end
      end
      asnz_pkg::CMD_SNOOZE: begin
        // Stop the ring and queue a re-fire; the deadline wraps at 2^32.
        if (ringing_flag) begin
          ringing_flag_next    = 1'b0;
          ringing_slot_next    = '0;
          snooze_flag_next     = 1'b1;
          snooze_slot_next     = ringing_slot;
          snooze_deadline_next = s1_item.epoch_seconds + EW'(snooze_secs);
          stop = 1'b1;
        end
      end
      asnz_pkg::CMD_DISMISS: begin
        stop                 = ringing_flag;
        ringing_flag_next    = 1'b0;
        ringing_slot_next    = '0;
        snooze_flag_next     = 1'b0;
        snooze_slot_next     = '0;
        snooze_deadline_next = '0;
      end
      default: begin
      end
    endcase
  end

  // Result word reflects the state after the step.
  always_comb begin
    result.ring_start      = start;
    result.ring_stop       = stop;
    result.ringing         = ringing_flag_next;
    result.ring_slot       = ringing_flag_next ? ringing_slot_next : '0;
    result.snooze_pending  = snooze_flag_next;
    result.snooze_for_slot = snooze_flag_next ? snooze_slot_next : '0;
    if (slot_ok) begin
      result.entry_hour    = alarm_hour_next[idx];
      result.entry_minute  = alarm_minute_next[idx];
      result.entry_enabled = alarm_enabled_next[idx];
    end else begin
      result.entry_hour    = '0;
      result.entry_minute  = '0;
      result.entry_enabled = 1'b0;
    end
  end

  // Commit state when the step's result moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      default_snooze_minutes <= asnz_pkg::DEFAULT_SNOOZE_RESET;
      for (int i = 0; i < NUM_ALARMS; i++) begin
        alarm_hour[i]        <= '0;
        alarm_minute[i]      <= '0;
        alarm_enabled[i]     <= 1'b0;
        last_fired_minute[i] <= asnz_pkg::MINUTE_NONE;
      end
      last_evaluated_minute <= asnz_pkg::MINUTE_NONE;
      ringing_flag    <= 1'b0;
      ringing_slot    <= '0;
      snooze_flag     <= 1'b0;
      snooze_slot     <= '0;
      snooze_deadline <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        default_snooze_minutes <= cfg_data;
      end
      if (s1_fire) begin
        for (int i = 0; i < NUM_ALARMS; i++) begin
          alarm_hour[i]        <= alarm_hour_next[i];
          alarm_minute[i]      <= alarm_minute_next[i];
          alarm_enabled[i]     <= alarm_enabled_next[i];
          last_fired_minute[i] <= last_fired_minute_next[i];
        end
        last_evaluated_minute <= last_evaluated_minute_next;
        ringing_flag    <= ringing_flag_next;
        ringing_slot    <= ringing_slot_next;
        snooze_flag     <= snooze_flag_next;
        snooze_slot     <= snooze_slot_next;
        snooze_deadline <= snooze_deadline_next;
      end
    end
  end

`ifndef SYNTHESIS
  // Ringing and a queued snooze exclude each other.
  a_ring_xor_snooze: assert property (@(posedge clk) disable iff (rst)
    !(ringing_flag && snooze_flag))
    else $error("ringing and snooze pending at once");

  // A word never both starts and stops a ring.
  a_start_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.ring_start && out_data.ring_stop))
    else $error("ring start and stop in one result");

  // A started ring is ringing in the same result.
  a_start_rings: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.ring_start) |-> out_data.ringing)
    else $error("ring start without ringing");

  // An empty input register never pushes back on the sender.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("stall with empty input stage");
`endif

endmodule

>>> sim/alarm_word_checker.sv
// Checker for the alarm slot block: watches the command, result and
// default-snooze channels, predicts each result word and compares it.
// Depends on asnz_pkg for the word layouts and command codes.
module alarm_word_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  asnz_pkg::in_t                 in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  asnz_pkg::out_t                out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [asnz_pkg::SNOOZE_W-1:0] cfg_data,
  output int unsigned                   mismatches,
  output int unsigned                   outstanding,
  output int unsigned                   words_checked,
  output int unsigned                   rings_started,
  output int unsigned                   snoozes_queued
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = asnz_pkg::NUM_ALARMS_DEFAULT;

  // Predicted block state
  logic [asnz_pkg::HOUR_W-1:0]   alarm_hr    [SLOTS];
  logic [asnz_pkg::MIN_W-1:0]    alarm_mn    [SLOTS];
  logic                          alarm_en    [SLOTS];
  logic [asnz_pkg::MINUTE_W-1:0] last_fired  [SLOTS];
  logic [asnz_pkg::MINUTE_W-1:0] last_eval;
  logic                          ring_on;
  logic [asnz_pkg::SLOT_W-1:0]   ring_slot_q;
  logic                          snz_on;
  logic [asnz_pkg::SLOT_W-1:0]   snz_slot;
  logic [asnz_pkg::EPOCH_W-1:0]  snz_deadline;
  logic [asnz_pkg::SNOOZE_W-1:0] snooze_dflt;

  asnz_pkg::out_t pending_results[$];
  int unsigned    err_count;
  int unsigned    checked_count;
  int unsigned    ring_count;
  int unsigned    snooze_count;

  function automatic void drop_snooze();
    snz_on       = 1'b0;
    snz_slot     = '0;
    snz_deadline = '0;
  endfunction

  function automatic void start_ring(input logic [asnz_pkg::SLOT_W-1:0] s,
                                     input logic [asnz_pkg::MINUTE_W-1:0] minute_now);
    ring_on       = 1'b1;
    ring_slot_q   = s;
    last_fired[s] = minute_now;
    drop_snooze();
  endfunction

  // Apply one command word to the predicted state and build its result word.
  function automatic asnz_pkg::out_t alarm_response(input asnz_pkg::in_t w);
    logic [asnz_pkg::MINUTE_W-1:0] minute_now;
    logic [asnz_pkg::SNOOZE_W-1:0] mins;
    logic                          started;
    logic                          stopped;
    int                            i;
    asnz_pkg::out_t                r;
    minute_now = asnz_pkg::MINUTE_W'(w.epoch_seconds / 32'd60);
    started    = 1'b0;
    stopped    = 1'b0;
    case (w.cmd)
      asnz_pkg::CMD_TICK: begin
        if (!ring_on) begin
          // a due snooze wins and skips the minute scan
          if (snz_on && w.epoch_seconds >= snz_deadline) begin
            start_ring(snz_slot, minute_now);
            started = 1'b1;
          end else if (minute_now != last_eval) begin
            last_eval = minute_now;
            for (i = 0; i < SLOTS; i++) begin
              if (!started && alarm_en[i] && alarm_hr[i] == w.clock_hour &&
                  alarm_mn[i] == w.clock_minute && last_fired[i] != minute_now) begin
                start_ring(asnz_pkg::SLOT_W'(i), minute_now);
                started = 1'b1;
              end
            end
          end
        end
      end
      asnz_pkg::CMD_SET: begin
        alarm_hr[w.slot] = (w.set_hour > 8'(asnz_pkg::MAX_HOUR))
                         ? asnz_pkg::MAX_HOUR : w.set_hour[asnz_pkg::HOUR_W-1:0];
        alarm_mn[w.slot] = (w.set_minute > 8'(asnz_pkg::MAX_MINUTE))
                         ? asnz_pkg::MAX_MINUTE : w.set_minute[asnz_pkg::MIN_W-1:0];
        alarm_en[w.slot] = w.set_enable;
        if (snz_on && snz_slot == w.slot) drop_snooze();
      end
      asnz_pkg::CMD_SNOOZE: begin
        if (ring_on) begin
          mins         = (w.snooze_minutes != '0) ? w.snooze_minutes : snooze_dflt;
          snz_on       = 1'b1;
          snz_slot     = ring_slot_q;
          snz_deadline = w.epoch_seconds + 32'(mins) * 32'd60;
          ring_on      = 1'b0;
          ring_slot_q  = '0;
          stopped      = 1'b1;
          snooze_count++;
        end
      end
      default: begin
        stopped     = ring_on;
        ring_on     = 1'b0;
        ring_slot_q = '0;
        drop_snooze();
      end
    endcase
    if (started) ring_count++;
    r.ring_start      = started;
    r.ring_stop       = stopped;
    r.ring_slot       = ring_on ? ring_slot_q : '0;
    r.ringing         = ring_on;
    r.snooze_pending  = snz_on;
    r.snooze_for_slot = snz_on ? snz_slot : '0;
    r.entry_hour      = alarm_hr[w.slot];
    r.entry_minute    = alarm_mn[w.slot];
    r.entry_enabled   = alarm_en[w.slot];
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want_v, got_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    asnz_pkg::out_t want;
    asnz_pkg::out_t got;
    int             i;
    if (rst) begin
      for (i = 0; i < SLOTS; i++) begin
        alarm_hr[i]   = '0;
        alarm_mn[i]   = '0;
        alarm_en[i]   = 1'b0;
        last_fired[i] = asnz_pkg::MINUTE_NONE;
      end
      last_eval   = asnz_pkg::MINUTE_NONE;
      ring_on     = 1'b0;
      ring_slot_q = '0;
      drop_snooze();
      snooze_dflt = asnz_pkg::DEFAULT_SNOOZE_RESET;
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) snooze_dflt = cfg_data;
      if (in_valid && !in_stall) pending_results.push_back(alarm_response(in_data));
      if (out_valid && !out_stall) begin
        got = out_data;
        if (pending_results.size() == 0) begin
          $display("%0t: result word with nothing expected, got %h", $time, got);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("ring_start", 32'(want.ring_start), 32'(got.ring_start));
          check_field("ring_stop", 32'(want.ring_stop), 32'(got.ring_stop));
          check_field("ring_slot", 32'(want.ring_slot), 32'(got.ring_slot));
          check_field("ringing", 32'(want.ringing), 32'(got.ringing));
          check_field("snooze_pending", 32'(want.snooze_pending),
                      32'(got.snooze_pending));
          check_field("snooze_for_slot", 32'(want.snooze_for_slot),
                      32'(got.snooze_for_slot));
          check_field("entry_hour", 32'(want.entry_hour), 32'(got.entry_hour));
          check_field("entry_minute", 32'(want.entry_minute), 32'(got.entry_minute));
          check_field("entry_enabled", 32'(want.entry_enabled), 32'(got.entry_enabled));
          checked_count++;
        end
      end
    end
    mismatches     <= err_count;
    outstanding    <= pending_results.size();
    words_checked  <= checked_count;
    rings_started  <= ring_count;
    snoozes_queued <= snooze_count;
  end

  initial begin
    err_count     = 0;
    checked_count = 0;
    ring_count    = 0;
    snooze_count  = 0;
  end

endmodule

>>> sim/alarm_slots_with_snooze_tb.sv
// Top of the alarm slot testbench: clock, reset, command and register
// stimulus, result-side stalls, watchdog and verdict.
// Depends on asnz_pkg, alarm_slots_with_snooze and alarm_word_checker.
module alarm_slots_with_snooze_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT   = 4000; // cycles with no handshake at all
  localparam int SETTLE_CYCLES = 8;    // covers the input and result registers
  localparam int PHASES        = 5;
  localparam int PHASE_ITEMS   = 230;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  asnz_pkg::in_t                 in_data   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  asnz_pkg::out_t                out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [asnz_pkg::SNOOZE_W-1:0] cfg_data  = '0;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned words_checked;
  int unsigned rings_started;
  int unsigned snoozes_queued;

  // Idle bursts on both sides are enabled by this flag.
  bit          idle_on = 1'b1;
  int unsigned quiet_cycles = 0;
  // Running wall clock for the random part; local time follows from it.
  logic [asnz_pkg::EPOCH_W-1:0] wall;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  alarm_slots_with_snooze dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  alarm_word_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .words_checked  (words_checked),
    .rings_started  (rings_started),
    .snoozes_queued (snoozes_queued)
  );

  // Stall the result side in random bursts while idling is on.
  always begin
    @(posedge clk);
    if (idle_on && !rst && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 19)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  // Watchdog: end the run when no channel moves a word for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Fully random word; the builders below override the fields that matter,
  // so the unused fields still toggle every bit.
  function automatic asnz_pkg::in_t noise_word();
    asnz_pkg::in_t w;
    w.cmd            = asnz_pkg::cmd_t'($urandom_range(0, 3));
    w.epoch_seconds  = $urandom;
    w.clock_hour     = asnz_pkg::HOUR_W'($urandom);
    w.clock_minute   = asnz_pkg::MIN_W'($urandom);
    w.slot           = asnz_pkg::SLOT_W'($urandom);
    w.set_hour       = 8'($urandom);
    w.set_minute     = 8'($urandom);
    w.set_enable     = 1'($urandom);
    w.snooze_minutes = asnz_pkg::SNOOZE_W'($urandom);
    return w;
  endfunction

  function automatic asnz_pkg::in_t tick_cmd(input logic [asnz_pkg::EPOCH_W-1:0] e,
                                             input logic [asnz_pkg::HOUR_W-1:0] h,
                                             input logic [asnz_pkg::MIN_W-1:0] m);
    asnz_pkg::in_t w;
    w               = noise_word();
    w.cmd           = asnz_pkg::CMD_TICK;
    w.epoch_seconds = e;
    w.clock_hour    = h;
    w.clock_minute  = m;
    return w;
  endfunction

  function automatic asnz_pkg::in_t set_cmd(input logic [asnz_pkg::SLOT_W-1:0] s,
                                            input logic [7:0] h,
                                            input logic [7:0] m, input logic en);
    asnz_pkg::in_t w;
    w            = noise_word();
    w.cmd        = asnz_pkg::CMD_SET;
    w.slot       = s;
    w.set_hour   = h;
    w.set_minute = m;
    w.set_enable = en;
    return w;
  endfunction

  function automatic asnz_pkg::in_t snooze_cmd(input logic [asnz_pkg::EPOCH_W-1:0] e,
                                               input logic [asnz_pkg::SNOOZE_W-1:0] n);
    asnz_pkg::in_t w;
    w                = noise_word();
    w.cmd            = asnz_pkg::CMD_SNOOZE;
    w.epoch_seconds  = e;
    w.snooze_minutes = n;
    return w;
  endfunction

  function automatic asnz_pkg::in_t dismiss_cmd();
    asnz_pkg::in_t w;
    w     = noise_word();
    w.cmd = asnz_pkg::CMD_DISMISS;
    return w;
  endfunction

  function automatic logic [asnz_pkg::HOUR_W-1:0] local_hour(
      input logic [asnz_pkg::EPOCH_W-1:0] e);
    return asnz_pkg::HOUR_W'((e / 32'd3600) % 32'd24);
  endfunction

  function automatic logic [asnz_pkg::MIN_W-1:0] local_minute(
      input logic [asnz_pkg::EPOCH_W-1:0] e);
    return asnz_pkg::MIN_W'((e / 32'd60) % 32'd60);
  endfunction

  // Present one command word and hold it until an edge with stall low takes
  // it. Valid stays high on return so back-to-back words need no extra edge.
  task automatic send_command(input asnz_pkg::in_t w);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk iff !in_stall);
  endtask

  // Drop valid, wait for every predicted result, then let the pipeline
  // drain before anything else touches the block.
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_default_snooze(input logic [asnz_pkg::SNOOZE_W-1:0] v);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One random command, biased toward sequences that actually ring:
  // mostly forward-moving ticks, alarms set just ahead of the wall clock,
  // short snoozes that come due, and a share of noise.
  task automatic random_command();
    int unsigned                   pick;
    logic [asnz_pkg::EPOCH_W-1:0]  target;
    logic [asnz_pkg::SNOOZE_W-1:0] n;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      case ($urandom_range(0, 19))
        0:       wall = $urandom;
        1:       wall = wall - $urandom_range(1, 600);
        default: wall = wall + $urandom_range(0, 90);
      endcase
      if ($urandom_range(0, 19) == 0)
        send_command(tick_cmd(wall, asnz_pkg::HOUR_W'($urandom),
                              asnz_pkg::MIN_W'($urandom)));
      else
        send_command(tick_cmd(wall, local_hour(wall), local_minute(wall)));
    end else if (pick < 70) begin
      if ($urandom_range(0, 5) == 0) begin
        send_command(set_cmd(asnz_pkg::SLOT_W'($urandom), 8'($urandom), 8'($urandom),
                             1'($urandom)));
      end else begin
        target = wall + $urandom_range(0, 240);
        send_command(set_cmd(asnz_pkg::SLOT_W'($urandom), 8'(local_hour(target)),
                             8'(local_minute(target)), $urandom_range(0, 7) != 0));
      end
    end else if (pick < 85) begin
      case ($urandom_range(0, 3))
        0:       n = '0;
        1, 2:    n = asnz_pkg::SNOOZE_W'($urandom_range(1, 3));
        default: n = asnz_pkg::SNOOZE_W'($urandom);
      endcase
      send_command(snooze_cmd(($urandom_range(0, 9) == 0) ? $urandom : wall, n));
    end else begin
      send_command(dismiss_cmd());
    end
  endtask

  initial begin
    logic [asnz_pkg::EPOCH_W-1:0]  e0;
    logic [asnz_pkg::SNOOZE_W-1:0] phase_dflt [PHASES];
    int                            p;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part: clamping, slot priority, ticks while ringing, snooze
    // with the reset default, edit cancelling a snooze, deadline wrap.
    e0 = 32'd37800;  // 10:30
    send_command(set_cmd(2'd0, 8'd255, 8'd255, 1'b1));  // clamps to 23:59
    send_command(set_cmd(2'd1, 8'd10, 8'd30, 1'b1));
    send_command(set_cmd(2'd2, 8'd10, 8'd30, 1'b1));
    send_command(set_cmd(2'd3, 8'd10, 8'd30, 1'b0));
    send_command(tick_cmd(e0, 5'd10, 6'd30));           // lowest enabled slot rings
    send_command(tick_cmd(e0 + 1, 5'd10, 6'd30));       // ringing: no change
    send_command(snooze_cmd(e0 + 2, 8'd0));             // reset default length
    send_command(tick_cmd(e0 + 3, 5'd10, 6'd30));       // minute already evaluated
    send_command(tick_cmd(e0 + 302, 5'd10, 6'd35));     // snooze exactly due
    send_command(dismiss_cmd());
    send_command(dismiss_cmd());                        // nothing ringing
    send_command(snooze_cmd(e0 + 400, 8'd7));           // ignored when idle
    send_command(tick_cmd(e0 + 420, 5'd31, 6'd63));     // out-of-range local time
    send_command(set_cmd(2'd2, 8'd11, 8'd0, 1'b1));
    send_command(tick_cmd(32'd39600, 5'd11, 6'd0));
    send_command(snooze_cmd(32'd39601, 8'd1));
    send_command(set_cmd(2'd2, 8'd11, 8'd5, 1'b1));     // edit cancels the snooze
    send_command(tick_cmd(32'hFFFF_FFF0, 5'd23, 6'd59));
    send_command(snooze_cmd(32'hFFFF_FFF0, 8'd255));    // deadline wraps past 2^32
    send_command(tick_cmd(32'hFFFF_FFFF, 5'd23, 6'd59));
    send_command(dismiss_cmd());

    // Zero default: a zero-length snooze comes due on the next idle tick.
    write_default_snooze(8'd0);
    send_command(set_cmd(2'd1, 8'd0, 8'd0, 1'b1));
    send_command(tick_cmd(32'd0, 5'd0, 6'd0));
    send_command(snooze_cmd(32'd5, 8'd0));
    send_command(tick_cmd(32'd5, 5'd0, 6'd0));
    send_command(dismiss_cmd());

    // Random part: one default setting per phase, extremes first. The
    // middle phase runs with no idling, and so does the last.
    phase_dflt[0] = 8'd1;
    phase_dflt[1] = 8'd255;
    phase_dflt[2] = asnz_pkg::DEFAULT_SNOOZE_RESET;
    phase_dflt[3] = asnz_pkg::SNOOZE_W'($urandom_range(2, 254));
    phase_dflt[4] = asnz_pkg::SNOOZE_W'($urandom);
    wall = $urandom;
    for (p = 0; p < PHASES; p++) begin
      write_default_snooze(phase_dflt[p]);
      idle_on = (p != 2) && (p != PHASES - 1);
      repeat (PHASE_ITEMS) random_command();
    end

    quiesce();
    $display("Checked %0d result words over %0d default-snooze settings.",
             words_checked, PHASES + 2);
    $display("Saw %0d rings started and %0d snoozes queued.", rings_started, snoozes_queued);
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
design/asnz_pkg.sv
design/alarm_slots_with_snooze.sv
sim/alarm_word_checker.sv
sim/alarm_slots_with_snooze_tb.sv
